### sv/lmb_pkg.sv
`timescale 1ns / 1ps

package lmb_pkg;

  // Width of the iteration count register.
  localparam int unsigned IterW = 7;
  // Width used to compare a count against a cell position (positions up to 255).
  localparam int unsigned PosW = 8;
  localparam logic [IterW-1:0] IterReset = 7'd30;

  // Control word that walks down the cell chain beside each grid point.
  typedef struct packed {
    logic             valid;
    logic [IterW-1:0] count;
  } lmb_ctrl_t;

endpackage

### sv/lmb_cell.sv
`timescale 1ns / 1ps

module lmb_cell import lmb_pkg::*; #(
  parameter int unsigned ROW_BITS       = 12,
  parameter int unsigned PRECISION_BITS = 24,
  parameter int unsigned POSITION       = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  lmb_ctrl_t                 ctrl_i,
  input  logic [PRECISION_BITS-1:0] x_i,
  input  logic [ROW_BITS+1:0]       rate_i,
  output lmb_ctrl_t                 ctrl_o,
  output logic [PRECISION_BITS-1:0] x_o,
  output logic [ROW_BITS+1:0]       rate_o
);

  localparam int unsigned P     = PRECISION_BITS;
  localparam int unsigned RateW = ROW_BITS + 2;
  // x*(1-x) is at most one quarter, so P-1 bits hold it.
  localparam int unsigned TW    = P - 1;
  localparam logic [PosW-1:0] Pos = PosW'(POSITION);
  localparam logic [P:0]      One = {1'b1, {P{1'b0}}};

  // First half: t = x*(1-x)
  lmb_ctrl_t          ctrl_a_q;
  logic               apply_a_q;
  logic [P-1:0]       x_a_q;
  logic [TW-1:0]      t_a_q;
  logic [RateW-1:0]   rate_a_q;

  logic [P:0]         one_minus_x;
  logic [2*P:0]       prod_a;
  logic               apply_d;

  assign one_minus_x = One - {1'b0, x_i};
  assign prod_a      = {{P{1'b0}}, 1'b0, x_i} * {{P{1'b0}}, one_minus_x};
  // Only cells below the item's count do work; the rest pass x on.
  assign apply_d     = ({1'b0, ctrl_i.count} > Pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
    end else if (en_i) begin
      ctrl_a_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      apply_a_q <= apply_d;
      x_a_q     <= x_i;
      t_a_q     <= prod_a[2*P-2:P];
      rate_a_q  <= rate_i;
    end
  end

  // Second half: x = r*t
  logic [RateW+TW-1:0] prod_b;
  logic [P-1:0]        x_b_d;
  lmb_ctrl_t           ctrl_b_q;
  logic [P-1:0]        x_b_q;
  logic [RateW-1:0]    rate_b_q;

  assign prod_b = {{TW{1'b0}}, rate_a_q} * {{RateW{1'b0}}, t_a_q};
  assign x_b_d  = apply_a_q ? prod_b[ROW_BITS+P-1:ROW_BITS] : x_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_b_q <= '0;
    end else if (en_i) begin
      ctrl_b_q <= ctrl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_b_q    <= x_b_d;
      rate_b_q <= rate_a_q;
    end
  end

  assign ctrl_o = ctrl_b_q;
  assign x_o    = x_b_q;
  assign rate_o = rate_b_q;

`ifndef SYNTHESIS
  a_valid_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> (ctrl_b_q.valid == $past(ctrl_a_q.valid)))
    else $error("cell second half lost or invented an item");
`endif

endmodule

### sv/logistic_map_bifurcation_pixel_core.sv
`timescale 1ns / 1ps
// Path: each grid point passes through both register halves of every cell, then the output register.
// Throughput: one grid point per cycle; each of the MAX_ITERATIONS cells holds two
//   multiplier stages, and the chain advances whenever the output skid slot is empty.
// Reset (rst_ni low, asynchronous): all valid flags clear, iteration_count returns to 30.

module logistic_map_bifurcation_pixel_core import lmb_pkg::*; #(
  parameter int unsigned ROW_BITS       = 12,
  parameter int unsigned PRECISION_BITS = 24,
  parameter int unsigned MAX_ITERATIONS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Iteration count register write channel.
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [IterW-1:0]                      cfg_data_i,
  // Grid point requests.
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // fields from bit 0: start_index [ROW_BITS], rate_index [ROW_BITS+2], zero fill
  input  logic [((2*ROW_BITS+2+7)/8)*8-1:0]     s_axis_tdata,
  // Pixel results.
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // fields from bit 0: pixel_row [ROW_BITS], pixel_column [ROW_BITS+2], zero fill
  output logic [((2*ROW_BITS+2+7)/8)*8-1:0]     m_axis_tdata
);

  localparam int unsigned P      = PRECISION_BITS;
  localparam int unsigned RateW  = ROW_BITS + 2;
  localparam int unsigned FieldW = ROW_BITS + RateW;
  localparam int unsigned TdataW = ((FieldW + 7) / 8) * 8;

  // Configuration register: writes are always taken.
  logic [IterW-1:0] iter_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_count_q <= IterReset;
    end else if (cfg_valid_i) begin
      iter_count_q <= cfg_data_i;
    end
  end

  // Saturate the count at the chain length; each item carries its own copy.
  logic [IterW-1:0] count_sat;
  assign count_sat = ({1'b0, iter_count_q} > PosW'(MAX_ITERATIONS)) ?
                     IterW'(MAX_ITERATIONS) : iter_count_q;

  // Chain enable: the whole row of cells moves together while the skid slot is free.
  logic skid_valid_q;
  logic chain_en;

  assign chain_en      = !skid_valid_q;
  assign s_axis_tready = chain_en;

  // Taps between cells; tap 0 is the chain head.
  lmb_ctrl_t        ctrl_tap [MAX_ITERATIONS+1];
  logic [P-1:0]     x_tap    [MAX_ITERATIONS+1];
  logic [RateW-1:0] rate_tap [MAX_ITERATIONS+1];

  logic [ROW_BITS-1:0] start_in;

  assign start_in          = s_axis_tdata[ROW_BITS-1:0];
  assign rate_tap[0]       = s_axis_tdata[FieldW-1:ROW_BITS];
  // x0 = start / 2^ROW_BITS in P fraction bits.
  assign x_tap[0]          = P'(start_in) << (P - ROW_BITS);
  assign ctrl_tap[0].valid = s_axis_tvalid;
  assign ctrl_tap[0].count = count_sat;

  for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_cell
    lmb_cell #(
      .ROW_BITS      (ROW_BITS),
      .PRECISION_BITS(PRECISION_BITS),
      .POSITION      (g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (chain_en),
      .ctrl_i(ctrl_tap[g]),
      .x_i   (x_tap[g]),
      .rate_i(rate_tap[g]),
      .ctrl_o(ctrl_tap[g+1]),
      .x_o   (x_tap[g+1]),
      .rate_o(rate_tap[g+1])
    );
  end

  // Map the final x to a row: top bits of x, counted from the bottom of the image.
  logic                chain_valid;
  logic [ROW_BITS-1:0] row_end;
  logic [RateW-1:0]    col_end;

  assign chain_valid = ctrl_tap[MAX_ITERATIONS].valid;
  assign row_end     = ~x_tap[MAX_ITERATIONS][P-1:P-ROW_BITS];
  assign col_end     = rate_tap[MAX_ITERATIONS];

  // Output register plus one skid slot, so a stalled result does not stop
  // the chain until a second result arrives behind it.
  logic                out_valid_q, out_valid_d;
  logic                skid_valid_d;
  logic [ROW_BITS-1:0] out_row_q, out_row_d, skid_row_q, skid_row_d;
  logic [RateW-1:0]    out_col_q, out_col_d, skid_col_q, skid_col_d;
  logic                out_take;

  assign out_take = out_valid_q && m_axis_tready;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    skid_row_d   = skid_row_q;
    skid_col_d   = skid_col_q;
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        // Drain the skid slot; the chain is held this cycle.
        out_valid_d  = 1'b1;
        out_row_d    = skid_row_q;
        out_col_d    = skid_col_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = chain_valid;
        out_row_d   = row_end;
        out_col_d   = col_end;
      end
    end else if (chain_en && chain_valid) begin
      // Park the arriving result behind the stalled one.
      skid_valid_d = 1'b1;
      skid_row_d   = row_end;
      skid_col_d   = col_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
    skid_row_q <= skid_row_d;
    skid_col_q <= skid_col_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TdataW'({out_col_q, out_row_q});

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a result while the output register is empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !m_axis_tready) |=> skid_valid_q)
    else $error("skid slot dropped a result that was never delivered");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, count_sat} <= PosW'(MAX_ITERATIONS))
    else $error("iteration count exceeds chain length");

  a_drain_holds_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_valid_q) |-> !chain_valid)
    else $error("chain produced a result while the skid slot was full");
`endif

endmodule
